/* design/ffa_pkg.sv */
// Shared constants, codes and types for the first-fit aligned free-list unit.
package ffa_pkg;

    localparam int MAX_INTERVALS = 512;
    localparam int ADDR_W        = 48;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int STAT_W        = 2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_RD,
        S_A_PAD,
        S_A_FIT,
        S_A_WR,
        S_R_PRE,
        S_R_RD,
        S_R_TOP,
        S_R_CMP,
        S_R_GLO,
        S_M_LO_TOP,
        S_M_LO_CMP,
        S_R_GHI,
        S_M_HI_CMP,
        S_E_CHK,
        S_E_WR,
        S_I_BEG,
        S_I_CHK,
        S_I_WR,
        S_DONE
    } t_state;

endpackage

/* design/ffa_if.sv */
// Valid/ready channel interfaces for requests and responses.
interface ffa_req_if;
    import ffa_pkg::*;
    logic  valid;
    logic  ready;
    logic  command;
    t_addr req_size;
    t_addr alignment;
    t_addr release_offset;
    t_addr release_padding;
    modport source (output valid, command, req_size, alignment, release_offset,
                    release_padding, input ready);
    modport sink   (input valid, command, req_size, alignment, release_offset,
                    release_padding, output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    t_addr             alloc_offset;
    t_addr             alloc_padding;
    t_cnt              free_count;
    modport source (output valid, status, alloc_offset, alloc_padding, free_count,
                    input ready);
    modport sink   (input valid, status, alloc_offset, alloc_padding, free_count,
                    output ready);
endinterface

/* design/first_fit_aligned_free_list_unit.sv */
// Top level: first-fit aligned free-interval allocator with coalescing.
//
//  channel   | dir | protocol            | content
//  i_req     | in  | valid/ready         | command, sizes, alignment, release info
//  o_rsp     | out | valid/ready         | status, offset, padding, free count
//  i_cfg_*   | in  | write enable, data  | pool_size (resets the table)
//
// One request at a time. Allocate scans the intervals in order until one fits.
// Release scans the intervals, then shifts entries up on insert or down on
// erase. The interval RAM takes one read and one write per cycle.
// Reset: table holds one interval (0, 0); no clearing pass. A held response
// does not stop the next request being taken; only its completion waits.
module first_fit_aligned_free_list_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ffa_req_if.sink                i_req,
    ffa_rsp_if.source              o_rsp,
    input  logic                   i_cfg_wr_en,
    input  logic [ffa_pkg::ADDR_W-1:0] i_cfg_wr_data
);
    import ffa_pkg::*;

    // interval RAM
    t_addr mem_s [MAX_INTERVALS];
    t_addr mem_l [MAX_INTERVALS];

    t_state r_state, n_state;
    logic   r_cmd;
    t_addr  r_size, r_align, r_mask, r_ao, r_pin;
    t_addr  r_off, r_sz, r_end, r_s, r_len, r_top, r_p, r_lmp, r_ns, r_nl;
    t_addr  n_off, n_sz, n_end, n_s, n_len, n_top, n_p, n_lmp, n_ns, n_nl;
    t_cnt   r_idx, n_idx, r_pos, n_pos, r_count, n_count;
    logic   r_e0_vld;
    t_status r_res_st, n_res_st;
    t_addr  r_res_off, n_res_off, r_res_pad, n_res_pad;

    logic   r_out_valid;
    t_status r_out_st;
    t_addr  r_out_off, r_out_pad;
    t_cnt   r_out_cnt;

    logic   wr_en;
    t_idx   wr_addr, rd_addr;
    t_addr  wr_s, wr_l;
    t_addr  r_rd_s, r_rd_l, rd_s, rd_l;
    logic   r_rd_zero;

    logic   req_xfer, out_free;
    t_addr  smear;

    assign req_xfer = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // ones at and below the highest set bit of the alignment
    always_comb begin
        smear = i_req.alignment;
        for (int k = 1; k < ADDR_W; k = k * 2) begin
            smear = smear | (smear >> k);
        end
    end

    // RAM read; entry 0 reads as zero until first written after reset
    always_ff @(posedge i_clk) begin
        r_rd_s <= mem_s[rd_addr];
        r_rd_l <= mem_l[rd_addr];
        if (i_cfg_wr_en) begin
            mem_s[0] <= '0;
            mem_l[0] <= i_cfg_wr_data;
        end else if (wr_en) begin
            mem_s[wr_addr] <= wr_s;
            mem_l[wr_addr] <= wr_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_zero <= 1'b0;
        end else begin
            r_rd_zero <= (rd_addr == '0) && !r_e0_vld;
        end
    end

    assign rd_s = r_rd_zero ? '0 : r_rd_s;
    assign rd_l = r_rd_zero ? '0 : r_rd_l;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_state = (i_req.command == CMD_RELEASE) ? S_R_PRE : S_A_RD;
                end
            end
            S_A_RD:     n_state = (r_idx >= r_count) ? S_DONE : S_A_PAD;
            S_A_PAD:    n_state = S_A_FIT;
            S_A_FIT: begin
                if ((r_p <= r_len) && (r_size <= r_len - r_p)) begin
                    n_state = S_A_WR;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_WR:     n_state = S_DONE;
            S_R_PRE:    n_state = S_R_RD;
            S_R_RD:     n_state = (r_idx >= r_count) ? S_I_BEG : S_R_TOP;
            S_R_TOP:    n_state = S_R_CMP;
            S_R_CMP: begin
                if (r_end == r_s) begin
                    n_state = S_R_GLO;
                end else if (r_off == r_top) begin
                    n_state = S_R_GHI;
                end else if (r_s > r_off) begin
                    n_state = S_I_BEG;
                end else begin
                    n_state = S_R_RD;
                end
            end
            S_R_GLO:    n_state = (r_idx != '0) ? S_M_LO_TOP : S_DONE;
            S_M_LO_TOP: n_state = S_M_LO_CMP;
            S_M_LO_CMP: n_state = (r_top == r_ns) ? S_E_CHK : S_DONE;
            S_R_GHI:    n_state = (r_idx + 1'b1 < r_count) ? S_M_HI_CMP : S_DONE;
            S_M_HI_CMP: n_state = (rd_s == r_end) ? S_E_CHK : S_DONE;
            S_E_CHK:    n_state = (r_idx + 1'b1 < r_count) ? S_E_WR : S_DONE;
            S_E_WR:     n_state = S_E_CHK;
            S_I_BEG:    n_state = (r_count >= t_cnt'(MAX_INTERVALS)) ? S_DONE : S_I_CHK;
            S_I_CHK:    n_state = (r_idx > r_pos) ? S_I_WR : S_DONE;
            S_I_WR:     n_state = S_I_CHK;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_off = r_off;  n_sz = r_sz;   n_end = r_end;  n_s = r_s;   n_len = r_len;
        n_top = r_top;  n_p = r_p;     n_lmp = r_lmp;  n_ns = r_ns; n_nl = r_nl;
        n_idx = r_idx;  n_pos = r_pos; n_count = r_count;
        n_res_st = r_res_st; n_res_off = r_res_off; n_res_pad = r_res_pad;
        wr_en = 1'b0; wr_addr = r_idx[IDX_W-1:0]; wr_s = r_s; wr_l = r_len;
        rd_addr = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_res_st = ST_OK; n_res_off = '0; n_res_pad = '0;
            end
            S_A_RD: begin
                if (r_idx >= r_count) begin
                    n_res_st = ST_NO_FIT;
                end
            end
            S_A_PAD: begin
                n_s   = rd_s;
                n_len = rd_l;
                n_p   = (r_align - (rd_s & r_mask)) & r_mask;
            end
            S_A_FIT: begin
                n_off = r_s + r_p;
                n_lmp = r_len - r_p;
                if (!((r_p <= r_len) && (r_size <= r_len - r_p))) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_A_WR: begin
                wr_en = 1'b1;
                wr_s = r_off + r_size;
                wr_l = r_lmp - r_size;
                n_res_off = r_off;
                n_res_pad = r_p;
            end
            S_R_PRE: begin
                n_off = r_ao - r_pin;
                n_sz  = r_size + r_pin;
                n_end = r_ao + r_size;   // off + sz
            end
            S_R_RD: ;
            S_R_TOP, S_M_LO_TOP: begin
                n_s   = rd_s;
                n_len = rd_l;
                n_top = rd_s + rd_l;
            end
            S_R_CMP: begin
                n_ns = r_s - r_sz;
                n_nl = r_len + r_sz;
                if ((r_end != r_s) && (r_off != r_top) && !(r_s > r_off)) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_R_GLO: begin
                wr_en = 1'b1;
                wr_s = r_ns;
                wr_l = r_nl;
                rd_addr = r_idx[IDX_W-1:0] - 1'b1;
            end
            S_M_LO_CMP: begin
                if (r_top == r_ns) begin
                    wr_en = 1'b1;
                    wr_addr = r_idx[IDX_W-1:0] - 1'b1;
                    wr_s = r_s;
                    wr_l = r_len + r_nl;
                end
            end
            S_R_GHI: begin
                wr_en = 1'b1;
                wr_s = r_s;
                wr_l = r_nl;
                rd_addr = r_idx[IDX_W-1:0] + 1'b1;
            end
            S_M_HI_CMP: begin
                if (rd_s == r_end) begin
                    wr_en = 1'b1;
                    wr_addr = r_idx[IDX_W-1:0] + 1'b1;
                    wr_s = rd_s - r_nl;
                    wr_l = rd_l + r_nl;
                end
            end
            S_E_CHK: begin
                rd_addr = r_idx[IDX_W-1:0] + 1'b1;
                if (!(r_idx + 1'b1 < r_count)) begin
                    n_count = r_count - 1'b1;
                end
            end
            S_E_WR: begin
                wr_en = 1'b1;
                wr_s = rd_s;
                wr_l = rd_l;
                n_idx = r_idx + 1'b1;
            end
            S_I_BEG: begin
                if (r_count >= t_cnt'(MAX_INTERVALS)) begin
                    n_res_st = ST_FULL;
                end else begin
                    n_pos = r_idx;
                    n_idx = r_count;
                end
            end
            S_I_CHK: begin
                rd_addr = r_idx[IDX_W-1:0] - 1'b1;
                if (!(r_idx > r_pos)) begin
                    wr_en = 1'b1;
                    wr_addr = r_pos[IDX_W-1:0];
                    wr_s = r_off;
                    wr_l = r_sz;
                    n_count = r_count + 1'b1;
                end
            end
            S_I_WR: begin
                wr_en = 1'b1;
                wr_s = rd_s;
                wr_l = rd_l;
                n_idx = r_idx - 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= t_cnt'(1);
            r_e0_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_count  <= t_cnt'(1);
                r_e0_vld <= 1'b1;
            end else begin
                r_count <= n_count;
                if (wr_en && (wr_addr == '0)) begin
                    r_e0_vld <= 1'b1;
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_off <= n_off; r_sz <= n_sz; r_end <= n_end; r_s <= n_s; r_len <= n_len;
        r_top <= n_top; r_p <= n_p; r_lmp <= n_lmp; r_ns <= n_ns; r_nl <= n_nl;
        r_idx <= n_idx; r_pos <= n_pos;
        r_res_st <= n_res_st; r_res_off <= n_res_off; r_res_pad <= n_res_pad;
        if (req_xfer) begin
            r_cmd   <= i_req.command;
            r_size  <= i_req.req_size;
            r_align <= i_req.alignment;
            r_mask  <= smear >> 1;
            r_ao    <= i_req.release_offset;
            r_pin   <= i_req.release_padding;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_st  <= r_res_st;
            r_out_off <= r_res_off;
            r_out_pad <= r_res_pad;
            r_out_cnt <= r_count;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_st;
    assign o_rsp.alloc_offset  = r_out_off;
    assign o_rsp.alloc_padding = r_out_pad;
    assign o_rsp.free_count    = r_out_cnt;

    // count in range, busy after take, response load, release gives no offset
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= t_cnt'(MAX_INTERVALS)))
        else $error("interval count out of range");
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> !i_req.ready)
        else $error("request taken while busy");
    a_rsp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_rsp.valid && r_state == S_IDLE))
        else $error("response not loaded on completion");
    a_release_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_RELEASE) |-> (r_res_off == '0))
        else $error("release produced an offset");

endmodule

/* bench/first_fit_aligned_free_list_unit_test.sv */
// Self-checking testbench for the first-fit aligned free-list unit.
module first_fit_aligned_free_list_unit_test;
    import ffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;
    localparam int PHASE_ITEMS = 160;
    localparam t_addr ADDR_MAX = {ADDR_W{1'b1}};

    typedef enum logic {ROW_POOL, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      command;
        t_addr     size;
        t_addr     align;
        t_addr     rel_off;
        t_addr     rel_pad;
        logic      typed;
        t_status   st;
        t_addr     off;
        t_addr     pad;
        t_cnt      cnt;
    } t_row;

    typedef struct {
        t_status st;
        t_addr   off;
        t_addr   pad;
        t_cnt    cnt;
    } t_grant;

    typedef struct {
        t_addr off;
        t_addr size;
        t_addr pad;
    } t_block;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_wr_en;
    t_addr i_cfg_wr_data;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_aligned_free_list_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // shadow copy of the free table
    t_addr  free_start [MAX_INTERVALS];
    t_addr  free_len   [MAX_INTERVALS];
    int     free_cnt;
    t_grant grants_due [$];
    t_block live_blocks [$];
    t_row   rows [$];
    int     errors;
    int     quiet_cycles;
    bit     idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_addr rand48();
        return t_addr'({$urandom, $urandom});
    endfunction

    function automatic void table_clear(input t_addr pool);
        for (int i = 0; i < MAX_INTERVALS; i++) begin
            free_start[i] = '0;
            free_len[i]   = '0;
        end
        free_len[0] = pool;
        free_cnt    = 1;
    endfunction

    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < free_cnt; i++) begin
            free_start[i] = free_start[i+1];
            free_len[i]   = free_len[i+1];
        end
        free_cnt--;
    endfunction

    function automatic t_grant first_fit(input t_addr size, input t_addr align);
        t_grant g;
        t_addr  mask, c, s, len, p;
        g = '{ST_NO_FIT, '0, '0, '0};
        mask = '0;
        c = align;
        while (c > 1) begin
            mask = {mask[ADDR_W-2:0], 1'b1};
            c = c >> 1;
        end
        for (int i = 0; i < free_cnt; i++) begin
            s = free_start[i];
            len = free_len[i];
            p = (align - (s & mask)) & mask;
            if (p <= len && size <= len - p) begin
                g.st = ST_OK;
                g.off = s + p;
                g.pad = p;
                free_start[i] = s + size + p;
                free_len[i] = len - (size + p);
                break;
            end
        end
        return g;
    endfunction

    function automatic t_status give_back(input t_addr aoff, input t_addr size,
                                          input t_addr pad);
        t_addr off, sz, stop, s, top;
        int    pos;
        bit    grown, lower;
        off = aoff - pad;
        sz = size + pad;
        stop = off + sz;
        grown = 0;
        lower = 0;
        for (pos = 0; pos < free_cnt; pos++) begin
            s = free_start[pos];
            top = s + free_len[pos];
            if (stop == s) begin
                free_start[pos] = s - sz;
                free_len[pos] = free_len[pos] + sz;
                grown = 1;
                lower = 1;
                break;
            end else if (off == top) begin
                free_len[pos] = free_len[pos] + sz;
                grown = 1;
                break;
            end else if (s > off) begin
                break;
            end
        end
        if (grown) begin
            if (lower) begin
                if (pos > 0 && free_start[pos-1] + free_len[pos-1] == free_start[pos]) begin
                    free_len[pos-1] = free_len[pos-1] + free_len[pos];
                    drop_entry(pos);
                end
            end else if (pos + 1 < free_cnt &&
                         free_start[pos] + free_len[pos] == free_start[pos+1]) begin
                free_start[pos+1] = free_start[pos+1] - free_len[pos];
                free_len[pos+1] = free_len[pos+1] + free_len[pos];
                drop_entry(pos);
            end
            return ST_OK;
        end
        if (free_cnt >= MAX_INTERVALS) return ST_FULL;
        for (int i = free_cnt; i > pos; i--) begin
            free_start[i] = free_start[i-1];
            free_len[i]   = free_len[i-1];
        end
        free_start[pos] = off;
        free_len[pos] = sz;
        free_cnt++;
        return ST_OK;
    endfunction

    function automatic t_grant predict_grant(input logic cmd, input t_addr size,
                                             input t_addr align, input t_addr roff,
                                             input t_addr rpad);
        t_grant g;
        if (cmd == CMD_ALLOC) begin
            g = first_fit(size, align);
            if (g.st == ST_OK) live_blocks.push_back('{g.off, size, g.pad});
        end else begin
            g = '{give_back(roff, size, rpad), '0, '0, '0};
        end
        g.cnt = t_cnt'(free_cnt);
        return g;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one request transfer; ready is sampled mid-cycle
    task automatic send(input logic cmd, input t_addr size, input t_addr align,
                        input t_addr roff, input t_addr rpad, input bit typed,
                        input t_grant want);
        t_grant g;
        bit     took;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.command         <= cmd;
        req_ch.req_size        <= size;
        req_ch.alignment       <= align;
        req_ch.release_offset  <= roff;
        req_ch.release_padding <= rpad;
        do begin
            @(negedge i_clk);
            took = req_ch.ready;
            if (took) begin
                quiet_cycles = 0;
                g = predict_grant(cmd, size, align, roff, rpad);
                grants_due.push_back(typed ? want : g);
            end
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic write_pool(input t_addr pool);
        req_ch.valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pool;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        table_clear(pool);
        live_blocks.delete();
    endtask

    task automatic add_row(input t_row_kind kind, input logic cmd, input t_addr size,
                           input t_addr align, input t_addr roff, input t_addr rpad,
                           input logic typed = 0, input t_status st = ST_OK,
                           input t_addr off = '0, input t_addr pad = '0,
                           input int cnt = 0);
        rows.push_back('{kind, cmd, size, align, roff, rpad, typed, st, off, pad, t_cnt'(cnt)});
    endtask

    task automatic random_item();
        int     pick, k;
        t_block b;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            k = $urandom_range(0, 9);
            send(CMD_ALLOC, ($urandom_range(0, 7) == 0) ? rand48() : t_addr'($urandom_range(0, 96)),
                 (k < 2) ? t_addr'(k) : (k < 8) ? t_addr'(1) << $urandom_range(1, 10)
                                                : t_addr'($urandom_range(2, 300)),
                 '0, '0, 0, '{ST_OK, '0, '0, '0});
        end else if (pick < 88 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            b = live_blocks[k];
            live_blocks.delete(k);
            send(CMD_RELEASE, b.size, rand48(), b.off, b.pad, 0, '{ST_OK, '0, '0, '0});
        end else begin
            send(logic'($urandom_range(0, 1)), rand48(), rand48(), rand48(), rand48(), 0,
                 '{ST_OK, '0, '0, '0});
        end
    endtask

    // response side: random stalls, mid-cycle sampling
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(negedge i_clk) begin
        t_grant w;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            quiet_cycles = 0;
            if (grants_due.size() == 0) begin
                report("unexpected transfer", rsp_ch.status, 0);
            end else begin
                w = grants_due.pop_front();
                if (rsp_ch.status !== w.st) report("status", rsp_ch.status, w.st);
                if (rsp_ch.alloc_offset !== w.off) report("offset", rsp_ch.alloc_offset, w.off);
                if (rsp_ch.alloc_padding !== w.pad) report("padding", rsp_ch.alloc_padding, w.pad);
                if (rsp_ch.free_count !== w.cnt) report("free count", rsp_ch.free_count, w.cnt);
            end
        end
    end

    always @(posedge i_clk) begin
        quiet_cycles++;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row r;
        errors = 0;
        quiet_cycles = 0;
        idle_on = 1;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_ALLOC;
        req_ch.req_size = '0;
        req_ch.alignment = '0;
        req_ch.release_offset = '0;
        req_ch.release_padding = '0;
        table_clear('0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: one empty interval
        add_row(ROW_REQ, CMD_ALLOC, 0, 0, 0, 0, 1, ST_OK, 0, 0, 1);
        add_row(ROW_REQ, CMD_ALLOC, 1, 0, 0, 0, 1, ST_NO_FIT, 0, 0, 1);
        add_row(ROW_REQ, CMD_RELEASE, 5, 0, 100, 0, 1, ST_OK, 0, 0, 2);    // append at end
        add_row(ROW_POOL, CMD_ALLOC, ADDR_MAX, 0, 0, 0);
        add_row(ROW_REQ, CMD_ALLOC, ADDR_MAX, 0, 0, 0, 1, ST_OK, 0, 0, 1);
        add_row(ROW_REQ, CMD_RELEASE, ADDR_MAX, 0, 0, 0, 1, ST_OK, 0, 0, 1);
        add_row(ROW_REQ, CMD_ALLOC, 16, 8, 0, 0);
        add_row(ROW_REQ, CMD_ALLOC, 3, ADDR_MAX, 0, 0);
        add_row(ROW_REQ, CMD_ALLOC, 1, 48'h8000_0000_0000, 0, 0);
        add_row(ROW_REQ, CMD_ALLOC, 7, 1, 0, 0);
        add_row(ROW_REQ, CMD_RELEASE, 16, 0, 0, 0);
        add_row(ROW_REQ, CMD_RELEASE, 4, 0, 32, 16);
        add_row(ROW_REQ, CMD_RELEASE, 2, 0, 4, 8);                          // padding wraps below 0
        add_row(ROW_REQ, CMD_RELEASE, 100, 0, 0, 0);                        // overlaps free space
        add_row(ROW_REQ, CMD_RELEASE, ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX);
        add_row(ROW_REQ, CMD_ALLOC, ADDR_MAX, ADDR_MAX, 0, 0);
        add_row(ROW_REQ, CMD_ALLOC, 0, 2, 0, 0);
        add_row(ROW_POOL, CMD_ALLOC, 64, 0, 0, 0);
        add_row(ROW_REQ, CMD_ALLOC, 8, 0, 0, 0, 1, ST_OK, 0, 0, 1);
        add_row(ROW_REQ, CMD_ALLOC, 8, 0, 0, 0, 1, ST_OK, 8, 0, 1);
        add_row(ROW_REQ, CMD_ALLOC, 8, 32, 0, 0, 1, ST_OK, 32, 16, 1);
        add_row(ROW_REQ, CMD_RELEASE, 8, 0, 0, 0, 1, ST_OK, 0, 0, 2);
        add_row(ROW_REQ, CMD_RELEASE, 8, 0, 32, 16, 1, ST_OK, 0, 0, 2);
        add_row(ROW_REQ, CMD_RELEASE, 8, 0, 8, 0, 1, ST_OK, 0, 0, 1);      // joins both sides
        add_row(ROW_REQ, CMD_ALLOC, 64, 0, 0, 0, 1, ST_OK, 0, 0, 1);

        foreach (rows[i]) begin
            r = rows[i];
            if (r.kind == ROW_POOL) begin
                write_pool(r.size);
            end else begin
                send(r.command, r.size, r.align, r.rel_off, r.rel_pad, r.typed,
                     '{r.st, r.off, r.pad, r.cnt});
            end
        end

        // fill the table with isolated intervals until a release is refused
        write_pool('0);
        for (int k = 1; k <= MAX_INTERVALS; k++)
            send(CMD_RELEASE, 1, 0, t_addr'(10 * k), 0, 0, '{ST_OK, '0, '0, '0});
        send(CMD_RELEASE, 1, 0, 11, 0, 0, '{ST_OK, '0, '0, '0});
        send(CMD_ALLOC, 1, 0, 0, 0, 0, '{ST_OK, '0, '0, '0});

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_pool(ADDR_MAX);
                1: write_pool(4096);
                2: write_pool(rand48());
                default: write_pool(t_addr'($urandom_range(1, 8192)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2) idle_on = 0;
                random_item();
            end
        end

        req_ch.valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
